>>> design/teadec_pkg.sv
`default_nettype none

package teadec_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam logic [WordW-1:0] Delta = 32'h9E37_79B9;

  typedef enum logic [CfgIdxW-1:0] {
    KEY_WORD_0 = 8'd0,
    KEY_WORD_1 = 8'd1,
    KEY_WORD_2 = 8'd2,
    KEY_WORD_3 = 8'd3
  } key_idx_e;

  typedef struct packed {
    logic [WordW-1:0] left;
    logic [WordW-1:0] right;
  } blk_t;

  typedef struct packed {
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
    logic [WordW-1:0] k2;
    logic [WordW-1:0] k3;
  } key_t;

  // Running sum seen by a round with the given number of rounds still to go.
  function automatic logic [WordW-1:0] round_sum(input int unsigned remaining);
    longint unsigned prod;
    prod = longint'(remaining) * longint'(Delta);
    return prod[WordW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/teadec_stage.sv
`default_nettype none

module teadec_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [teadec_pkg::WordW-1:0] src_i,
  input  wire logic [teadec_pkg::WordW-1:0] dst_i,
  input  wire logic [teadec_pkg::WordW-1:0] sum_i,
  input  wire logic [teadec_pkg::WordW-1:0] ka_i,
  input  wire logic [teadec_pkg::WordW-1:0] kb_i,
  output logic                              valid_o,
  output logic [teadec_pkg::WordW-1:0]      src_o,
  output logic [teadec_pkg::WordW-1:0]      dst_o
);

  logic                         valid_q;
  logic [teadec_pkg::WordW-1:0] src_q;
  logic [teadec_pkg::WordW-1:0] dst_q;
  logic [teadec_pkg::WordW-1:0] mix;
  logic [teadec_pkg::WordW-1:0] dst_d;

  always_comb begin
    mix   = ((src_i << 4) + ka_i) ^ (src_i + sum_i) ^ ((src_i >> 5) + kb_i);
    dst_d = dst_i - mix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      src_q <= src_i;
      dst_q <= dst_d;
    end
  end

  assign valid_o = valid_q;
  assign src_o   = src_q;
  assign dst_o   = dst_q;

endmodule

`default_nettype wire

>>> design/teadec_outbuf.sv
`default_nettype none

module teadec_outbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              tail_valid_i,
  input  wire teadec_pkg::blk_t  tail_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output teadec_pkg::blk_t       out_o
);

  logic             out_valid_q;
  logic             skid_valid_q;
  teadec_pkg::blk_t out_q;
  teadec_pkg::blk_t skid_q;
  logic             push;
  logic             out_busy;

  // The pipeline moves only while the skid slot is free, so every item that
  // leaves the last stage finds a place here.
  assign advance_o = !skid_valid_q;
  assign push      = advance_o && tail_valid_i;
  assign out_busy  = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_busy) begin
      if (push) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_busy) begin
      if (push) begin
        skid_q <= tail_i;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (push) begin
      out_q <= tail_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a request while the output register is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_busy && push) |=> skid_valid_q)
    else $error("request leaving the pipeline was not caught by the skid slot");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (!skid_valid_q && out_valid_q))
    else $error("skid slot did not move into the output register");

  a_skid_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid slot filled without an output stall");

endmodule

`default_nettype wire

>>> design/tea_block_decrypt.sv
`default_nettype none

// Channel   Direction  Handshake                      Payload
// in        sink       in_valid_i / in_ready_o        cipher_left_i, cipher_right_i
// out       source     out_valid_o / out_ready_i      plain_left_o, plain_right_o
// cfg       sink       cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One request enters per cycle unless the skid slot is full and holds the pipeline;
// each round is two register stages, one per half round; the output register follows them.
// Reset clears the valid bits and the key words; no clearing pass is needed.
// When the output is stalled a skid slot takes one more result, then the pipeline holds.

module tea_block_decrypt #(
  parameter int unsigned Rounds = teadec_pkg::Rounds
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [teadec_pkg::WordW-1:0]   cipher_left_i,
  input  wire logic [teadec_pkg::WordW-1:0]   cipher_right_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [teadec_pkg::WordW-1:0]        plain_left_o,
  output logic [teadec_pkg::WordW-1:0]        plain_right_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [teadec_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [teadec_pkg::WordW-1:0]   cfg_data_i
);

  localparam int unsigned Stages = 2 * Rounds;

  teadec_pkg::key_t             key_q;
  logic                         advance;
  logic                         vld   [Stages+1];
  logic [teadec_pkg::WordW-1:0] lft   [Stages+1];
  logic [teadec_pkg::WordW-1:0] rgt   [Stages+1];
  teadec_pkg::blk_t             tail;
  teadec_pkg::blk_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        teadec_pkg::KEY_WORD_0: key_q.k0 <= cfg_data_i;
        teadec_pkg::KEY_WORD_1: key_q.k1 <= cfg_data_i;
        teadec_pkg::KEY_WORD_2: key_q.k2 <= cfg_data_i;
        teadec_pkg::KEY_WORD_3: key_q.k3 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = advance;
  assign vld[0]     = in_valid_i && advance;
  assign lft[0]     = cipher_left_i;
  assign rgt[0]     = cipher_right_i;

  for (genvar h = 0; h < Stages; h++) begin : g_half
    localparam logic [teadec_pkg::WordW-1:0] Sum =
      teadec_pkg::round_sum(Rounds - (h / 2));
    if ((h % 2) == 0) begin : g_right
      teadec_stage u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (advance),
        .valid_i (vld[h]),
        .src_i   (lft[h]),
        .dst_i   (rgt[h]),
        .sum_i   (Sum),
        .ka_i    (key_q.k2),
        .kb_i    (key_q.k3),
        .valid_o (vld[h+1]),
        .src_o   (lft[h+1]),
        .dst_o   (rgt[h+1])
      );
    end else begin : g_left
      teadec_stage u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (advance),
        .valid_i (vld[h]),
        .src_i   (rgt[h]),
        .dst_i   (lft[h]),
        .sum_i   (Sum),
        .ka_i    (key_q.k0),
        .kb_i    (key_q.k1),
        .valid_o (vld[h+1]),
        .src_o   (rgt[h+1]),
        .dst_o   (lft[h+1])
      );
    end
  end

  assign tail.left  = lft[Stages];
  assign tail.right = rgt[Stages];

  teadec_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tail_valid_i (vld[Stages]),
    .tail_i       (tail),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res)
  );

  assign plain_left_o  = res.left;
  assign plain_right_o = res.right;

endmodule

`default_nettype wire
